// ===== rtl/core/chm_pkg.sv =====
package chm_pkg;

    localparam int ADDR_W          = 32;
    localparam int OFFSET_BITS     = 6;
    localparam int TAG_W           = 26;
    localparam int CNT_W           = 64;
    localparam int LOG2_W          = 3;
    localparam int LOG2_MAX        = 6;
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int BLOCK_BYTES_DEF = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULLY_ASSOC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT       = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch incoming address/kind
        logic lookup;   // compare cycle: register hit
        logic update;   // fill, pointer, counters, load output
    } cmd_t;

endpackage

// ===== rtl/core/chm_if.sv =====
interface chm_req_if;
    logic                          valid;
    logic                          ready;
    logic [chm_pkg::ADDR_W-1:0]    address;
    logic                          kind;

    modport source (output valid, output address, output kind, input ready);
    modport sink   (input valid, input address, input kind, output ready);
endinterface

interface chm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [chm_pkg::CNT_W-1:0]     access_total;
    logic [chm_pkg::CNT_W-1:0]     hit_total;

    modport source (output valid, output hit, output access_total, output hit_total,
                    input ready);
    modport sink   (input valid, input hit, input access_total, input hit_total,
                    output ready);
endinterface

interface chm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [chm_pkg::CFG_IDX_W-1:0]   index;
    logic [chm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/chm_ctrl.sv =====
module chm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output chm_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) || ((state_reg == S_UPDATE) && out_free);
    assign out_valid = out_valid_reg;

    assign cmd.capture = in_valid && in_ready;
    assign cmd.lookup  = (state_reg == S_LOOK);
    assign cmd.update  = (state_reg == S_UPDATE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (out_free)
                    state_next = cmd.capture ? S_LOOK : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.update)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // no new beat while the tags are being compared
    a_no_accept_in_look: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> !cmd.capture)
        else $error("input accepted during compare cycle");

    // a compare is always followed by the fill cycle
    a_look_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> (state_reg == S_UPDATE))
        else $error("compare not followed by fill");

    // fill only stalls on a held, untaken result
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UPDATE) && !cmd.update) |-> (out_valid_reg && !out_ready))
        else $error("fill stalled without output back-pressure");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> out_valid_reg)
        else $error("result not presented after fill");

endmodule

// ===== rtl/core/chm_datapath.sv =====
module chm_datapath #(
    parameter int MAX_ENTRIES = chm_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  chm_pkg::cmd_t                   cmd,
    input  logic                            cfg_write,
    input  logic [chm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [chm_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [chm_pkg::ADDR_W-1:0]      address,
    input  logic                            kind,
    output logic                            hit,
    output logic [chm_pkg::CNT_W-1:0]       access_total,
    output logic [chm_pkg::CNT_W-1:0]       hit_total
);

    // floor(log2(MAX_ENTRIES)), capped at the architectural maximum
    localparam int MAX_LG_RAW = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int MAX_LG     = (MAX_LG_RAW > chm_pkg::LOG2_MAX) ? chm_pkg::LOG2_MAX
                                                                  : MAX_LG_RAW;
    localparam int NUM_ENTRIES = 1 << MAX_LG;
    localparam int EN_W        = MAX_LG;

    // config registers
    logic [chm_pkg::LOG2_W-1:0] log2_reg;
    logic                       fa_reg;
    logic                       split_reg;

    // captured access
    logic [chm_pkg::ADDR_W-1:0] addr_reg;
    logic                       kind_reg;

    // tag store
    logic [NUM_ENTRIES-1:0]     valid_reg;
    logic [chm_pkg::TAG_W-1:0]  tag_reg [NUM_ENTRIES];
    logic [EN_W-1:0]            iptr_reg;
    logic [EN_W-1:0]            dptr_reg;

    logic                       hit_reg;
    logic [chm_pkg::CNT_W-1:0]  acc_cnt_reg;
    logic [chm_pkg::CNT_W-1:0]  hit_cnt_reg;
    logic                       out_hit_reg;
    logic [chm_pkg::CNT_W-1:0]  out_acc_reg;
    logic [chm_pkg::CNT_W-1:0]  out_hits_reg;

    // derived lookup values
    logic [chm_pkg::LOG2_W-1:0] lg_clamp;
    logic [chm_pkg::LOG2_W-1:0] lg;
    logic [chm_pkg::LOG2_W-1:0] region_lg;
    logic [chm_pkg::LOG2_W-1:0] set_bits;
    logic                       data_half;
    logic [EN_W-1:0]            region_mask;
    logic [EN_W-1:0]            base;
    logic [chm_pkg::TAG_W-1:0]  tag;
    logic [EN_W-1:0]            dm_victim;
    logic [EN_W-1:0]            fifo_pos;
    logic [EN_W-1:0]            victim;
    logic [NUM_ENTRIES-1:0]     match;
    logic                       any_match;

    always_comb
    begin
        if (log2_reg == '0)
            lg_clamp = chm_pkg::LOG2_W'(1);
        else if (log2_reg > chm_pkg::LOG2_W'(chm_pkg::LOG2_MAX))
            lg_clamp = chm_pkg::LOG2_W'(chm_pkg::LOG2_MAX);
        else
            lg_clamp = log2_reg;
        lg = (lg_clamp > chm_pkg::LOG2_W'(MAX_LG)) ? chm_pkg::LOG2_W'(MAX_LG) : lg_clamp;
    end

    assign data_half   = split_reg && kind_reg;
    assign region_lg   = split_reg ? (lg - chm_pkg::LOG2_W'(1)) : lg;
    assign set_bits    = fa_reg ? '0 : region_lg;
    assign region_mask = ~({EN_W{1'b1}} << region_lg);
    assign base        = data_half ? (EN_W'(1) << (lg - chm_pkg::LOG2_W'(1))) : '0;
    assign tag         = chm_pkg::TAG_W'(addr_reg[chm_pkg::ADDR_W-1:chm_pkg::OFFSET_BITS]
                                         >> set_bits);
    assign dm_victim   = base + (addr_reg[chm_pkg::OFFSET_BITS +: EN_W] & region_mask);
    assign fifo_pos    = (data_half ? dptr_reg : iptr_reg) & region_mask;
    assign victim      = fa_reg ? (base + fifo_pos) : dm_victim;

    // every entry compares in place; the select mask picks the region or the indexed entry
    always_comb
    begin
        logic [EN_W:0] offs;
        logic          sel;
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            offs = {1'b0, EN_W'(e)} - {1'b0, base};
            if (fa_reg)
                sel = (offs <= {1'b0, region_mask});
            else
                sel = (EN_W'(e) == dm_victim);
            match[e] = sel && valid_reg[e] && (tag_reg[e] == tag);
        end
    end

    assign any_match = |match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg    <= chm_pkg::LOG2_W'(chm_pkg::LOG2_MAX);
            fa_reg      <= 1'b0;
            split_reg   <= 1'b0;
            valid_reg   <= '0;
            iptr_reg    <= '0;
            dptr_reg    <= '0;
            acc_cnt_reg <= '0;
            hit_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    chm_pkg::CFG_ENTRY_LOG2:  log2_reg  <= cfg_data;
                    chm_pkg::CFG_FULLY_ASSOC: fa_reg    <= cfg_data[0];
                    chm_pkg::CFG_SPLIT:       split_reg <= cfg_data[0];
                    default:                  ;
                endcase
            end
            if (cmd.update)
            begin
                acc_cnt_reg <= acc_cnt_reg + chm_pkg::CNT_W'(1);
                hit_cnt_reg <= hit_cnt_reg + chm_pkg::CNT_W'(hit_reg);
                if (!hit_reg)
                begin
                    valid_reg[victim] <= 1'b1;
                    if (fa_reg)
                    begin
                        if (data_half)
                            dptr_reg <= (fifo_pos + EN_W'(1)) & region_mask;
                        else
                            iptr_reg <= (fifo_pos + EN_W'(1)) & region_mask;
                    end
                end
            end
        end
    end

    // payload: captured access, tags, compare result, output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= address;
            kind_reg <= kind;
        end
        if (cmd.lookup)
            hit_reg <= any_match;
        if (cmd.update)
        begin
            if (!hit_reg)
                tag_reg[victim] <= tag;
            out_hit_reg  <= hit_reg;
            out_acc_reg  <= acc_cnt_reg + chm_pkg::CNT_W'(1);
            out_hits_reg <= hit_cnt_reg + chm_pkg::CNT_W'(hit_reg);
        end
    end

    assign hit          = out_hit_reg;
    assign access_total = out_acc_reg;
    assign hit_total    = out_hits_reg;

    a_fill_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && !hit_reg) |=> valid_reg[$past(victim)])
        else $error("filled entry not valid");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> (acc_cnt_reg == $past(acc_cnt_reg) + chm_pkg::CNT_W'(1)))
        else $error("access count did not advance by one");

endmodule

// ===== rtl/core/cache_hit_miss_model.sv =====
// Channel  Dir  Payload                               Handshake
// req      in   address[31:0], kind                   req.valid / req.ready
// rsp      out  hit, access_total[63:0], hit_total    rsp.valid / rsp.ready
// cfg      in   index[1:0], data[2:0]                 cfg.valid / cfg.ready (always ready)
//
// Each beat has a compare cycle, matching the tag to every region entry in
// parallel, then a fill cycle that steps the counters, loads the output
// register and on a miss writes the single tag-store port and FIFO pointer.
// Reset clears the valid bits, FIFO pointers and counters at once; no sweep.
// The next request is taken during the fill cycle when the output register is
// free; a result left untaken holds the fill cycle and blocks new requests.
module cache_hit_miss_model #(
    parameter int MAX_ENTRIES = chm_pkg::MAX_ENTRIES_DEF,
    parameter int BLOCK_BYTES = chm_pkg::BLOCK_BYTES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    chm_req_if.sink   req,
    chm_rsp_if.source rsp,
    chm_cfg_if.sink   cfg
);

    chm_pkg::cmd_t cmd;
    logic          in_ready;
    logic          out_valid;

    // config writes land directly in the datapath registers
    assign cfg.ready = 1'b1;
    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

    chm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    chm_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_write    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .address      (req.address),
        .kind         (req.kind),
        .hit          (rsp.hit),
        .access_total (rsp.access_total),
        .hit_total    (rsp.hit_total)
    );

    // block size is fixed by the 6-bit offset field
    a_block_size: assert property (@(posedge clk) disable iff (!rst_n)
        (BLOCK_BYTES == (1 << chm_pkg::OFFSET_BITS)))
        else $error("block size does not match offset field");

endmodule
